[sv/pidpi_pkg.sv]
package pidpi_pkg;

  // Configuration register index
  localparam int CFG_INDEX_W = 3;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_LOOP_MODE      = 3'd0;
  localparam cfg_index_t REG_PROP_GAIN      = 3'd1;
  localparam cfg_index_t REG_INTEG_GAIN     = 3'd2;
  localparam cfg_index_t REG_DERIV_GAIN     = 3'd3;
  localparam cfg_index_t REG_OUTPUT_MIN     = 3'd4;
  localparam cfg_index_t REG_OUTPUT_MAX     = 3'd5;
  localparam cfg_index_t REG_INTEG_LIMIT    = 3'd6;

  // Loop forms
  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

endpackage

[sv/pidpi_ifs.sv]
// Sample request channel: measurement and setpoint
interface pidpi_sample_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measured_value;
  logic signed [DATA_WIDTH-1:0] target_value;

  modport source (output valid, measured_value, target_value, input ready);
  modport sink   (input valid, measured_value, target_value, output ready);
endinterface

// Drive request channel: clamped controller output
interface pidpi_drive_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink   (input valid, drive_value, output ready);
endinterface

[sv/pid_position_or_incremental.sv]
// Channel   Dir  Payload                              Handshake
// sample    in   measured_value, target_value         valid / ready
// drive     out  drive_value                          valid / ready
// cfg       in   cfg_index, cfg_data                  cfg_we (no back-pressure)
//
// One sample per cycle sustained while the drive channel is ready; a result
// passes through the input, error, product and output registers.
// The rate is set by the output stage: saturating adds into the accumulator
// and the clamp are combinational, so the next sample can use the new state.
// Each stage has its own valid bit, so a held result only stalls once the
// pipeline behind it is full. Reset clears valid bits, error history,
// accumulator and configuration; coefficients are registered from the configuration.
module pid_position_or_incremental #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  pidpi_sample_if.sink          sample,
  pidpi_drive_if.source         drive,
  input  logic                  cfg_we,
  input  pidpi_pkg::cfg_index_t cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);
  import pidpi_pkg::*;

  localparam int W = DATA_WIDTH;

  logic                loop_mode;
  logic signed [W-1:0] gain0;
  logic signed [W-1:0] gain1;
  logic signed [W-1:0] gain2;
  logic signed [W-1:0] output_minimum;
  logic signed [W-1:0] output_maximum;
  logic [W-2:0]        integral_limit;

  logic                err_valid;
  logic                err_ready;
  logic signed [W-1:0] err0;
  logic signed [W-1:0] err1;
  logic signed [W-1:0] err2;

  logic                prod_valid;
  logic                prod_ready;
  logic signed [W-1:0] prod0;
  logic signed [W-1:0] prod1;
  logic signed [W-1:0] prod2;
  logic signed [W-1:0] prod_err;

  pidpi_cfg #(.DATA_WIDTH(DATA_WIDTH)) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .loop_mode      (loop_mode),
    .gain0          (gain0),
    .gain1          (gain1),
    .gain2          (gain2),
    .output_minimum (output_minimum),
    .output_maximum (output_maximum),
    .integral_limit (integral_limit)
  );

  pidpi_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .next_ready (err_ready),
    .err_valid  (err_valid),
    .err0       (err0),
    .err1       (err1),
    .err2       (err2)
  );

  pidpi_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk        (clk),
    .rst        (rst),
    .loop_mode  (loop_mode),
    .gain0      (gain0),
    .gain1      (gain1),
    .gain2      (gain2),
    .err_valid  (err_valid),
    .err0       (err0),
    .err1       (err1),
    .err2       (err2),
    .err_ready  (err_ready),
    .next_ready (prod_ready),
    .prod_valid (prod_valid),
    .prod0      (prod0),
    .prod1      (prod1),
    .prod2      (prod2),
    .prod_err   (prod_err)
  );

  pidpi_acc #(.DATA_WIDTH(DATA_WIDTH)) u_acc (
    .clk            (clk),
    .rst            (rst),
    .loop_mode      (loop_mode),
    .output_minimum (output_minimum),
    .output_maximum (output_maximum),
    .integral_limit (integral_limit),
    .prod_valid     (prod_valid),
    .prod0          (prod0),
    .prod1          (prod1),
    .prod2          (prod2),
    .prod_err       (prod_err),
    .prod_ready     (prod_ready),
    .drive          (drive)
  );

  // A new result only comes from a full product stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (drive.valid && !$past(drive.valid)) |-> $past(prod_valid))
    else $error("result appeared without a product");

  // A held result keeps the product stage occupied
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (prod_valid && drive.valid && !drive.ready) |=> prod_valid)
    else $error("product lost during output stall");

  // Fresh result lies within ordered clamp bounds
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    (drive.valid && !$past(drive.valid) && !$past(cfg_we) &&
     output_minimum <= output_maximum) |->
    (drive.drive_value >= output_minimum && drive.drive_value <= output_maximum))
    else $error("drive value outside clamp bounds");

endmodule

[sv/pidpi_cfg.sv]
module pidpi_cfg #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  pidpi_pkg::cfg_index_t        cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_data,
  output logic                         loop_mode,
  output logic signed [DATA_WIDTH-1:0] gain0,
  output logic signed [DATA_WIDTH-1:0] gain1,
  output logic signed [DATA_WIDTH-1:0] gain2,
  output logic signed [DATA_WIDTH-1:0] output_minimum,
  output logic signed [DATA_WIDTH-1:0] output_maximum,
  output logic [DATA_WIDTH-2:0]        integral_limit
);
  import pidpi_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ZERO = '0;

  logic signed [W-1:0] proportional_gain;
  logic signed [W-1:0] integral_gain;
  logic signed [W-1:0] derivative_gain;
  logic signed [W-1:0] gain0_next;
  logic signed [W-1:0] gain1_next;
  logic signed [W-1:0] gain2_next;

  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) add_s = s[W] ? SMIN : SMAX;
    else add_s = s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) sub_s = s[W] ? SMIN : SMAX;
    else sub_s = s[W-1:0];
  endfunction

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode         <= MODE_POSITIONAL;
      proportional_gain <= '0;
      integral_gain     <= '0;
      derivative_gain   <= '0;
      output_minimum    <= SMIN;
      output_maximum    <= SMAX;
      integral_limit    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOOP_MODE:   loop_mode         <= cfg_data[0];
        REG_PROP_GAIN:   proportional_gain <= cfg_data;
        REG_INTEG_GAIN:  integral_gain     <= cfg_data;
        REG_DERIV_GAIN:  derivative_gain   <= cfg_data;
        REG_OUTPUT_MIN:  output_minimum    <= cfg_data;
        REG_OUTPUT_MAX:  output_maximum    <= cfg_data;
        REG_INTEG_LIMIT: integral_limit    <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // Per-tap coefficients for the selected loop form
  always_comb begin
    if (loop_mode == MODE_INCREMENTAL) begin
      gain0_next = add_s(add_s(proportional_gain, integral_gain), derivative_gain);
      gain1_next = sub_s(sub_s(ZERO, proportional_gain),
                         add_s(derivative_gain, derivative_gain));
      gain2_next = derivative_gain;
    end else begin
      gain0_next = add_s(proportional_gain, derivative_gain);
      gain1_next = sub_s(ZERO, derivative_gain);
      gain2_next = integral_gain;
    end
  end

  // Coefficients are registered from the configuration registers
  always_ff @(posedge clk) begin
    gain0 <= gain0_next;
    gain1 <= gain1_next;
    gain2 <= gain2_next;
  end

endmodule

[sv/pidpi_front.sv]
module pidpi_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  pidpi_sample_if.sink                 sample,
  input  logic                         next_ready,
  output logic                         err_valid,
  output logic signed [DATA_WIDTH-1:0] err0,
  output logic signed [DATA_WIDTH-1:0] err1,
  output logic signed [DATA_WIDTH-1:0] err2
);

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic                in_valid;
  logic signed [W-1:0] meas;
  logic signed [W-1:0] targ;
  logic signed [W-1:0] last_error;
  logic signed [W-1:0] older_error;
  logic signed [W-1:0] err_new;
  logic                in_ready;
  logic                err_ready;

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) sub_s = s[W] ? SMIN : SMAX;
    else sub_s = s[W-1:0];
  endfunction

  assign err_ready    = !err_valid || next_ready;
  assign in_ready     = !in_valid || err_ready;
  assign sample.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && sample.valid) begin
      meas <= sample.measured_value;
      targ <= sample.target_value;
    end
  end

  assign err_new = sub_s(targ, meas);

  // Error stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid <= 1'b0;
    end else if (err_ready) begin
      err_valid <= in_valid;
    end
  end

  // Error history shifts once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error  <= '0;
      older_error <= '0;
    end else if (err_ready && in_valid) begin
      last_error  <= err_new;
      older_error <= last_error;
    end
  end

  always_ff @(posedge clk) begin
    if (err_ready && in_valid) begin
      err0 <= err_new;
      err1 <= last_error;
      err2 <= older_error;
    end
  end

endmodule

[sv/pidpi_mul.sv]
module pidpi_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         loop_mode,
  input  logic signed [DATA_WIDTH-1:0] gain0,
  input  logic signed [DATA_WIDTH-1:0] gain1,
  input  logic signed [DATA_WIDTH-1:0] gain2,
  input  logic                         err_valid,
  input  logic signed [DATA_WIDTH-1:0] err0,
  input  logic signed [DATA_WIDTH-1:0] err1,
  input  logic signed [DATA_WIDTH-1:0] err2,
  output logic                         err_ready,
  input  logic                         next_ready,
  output logic                         prod_valid,
  output logic signed [DATA_WIDTH-1:0] prod0,
  output logic signed [DATA_WIDTH-1:0] prod1,
  output logic signed [DATA_WIDTH-1:0] prod2,
  output logic signed [DATA_WIDTH-1:0] prod_err
);
  import pidpi_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam logic signed [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [PW-1:0] RND  = PW'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [W-1:0] tap2_err;

  // Fixed-point product, truncated toward zero, saturated
  function automatic logic signed [W-1:0] mul_q(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    p = PW'(a) * PW'(b);
    if (p[PW-1]) p = p + RND;
    q = p >>> FRAC_BITS;
    if (q > PW'(SMAX)) mul_q = SMAX;
    else if (q < PW'(SMIN)) mul_q = SMIN;
    else mul_q = q[W-1:0];
  endfunction

  assign err_ready = !prod_valid || next_ready;
  // Third tap: integral term in positional form, oldest error otherwise
  assign tap2_err  = (loop_mode == MODE_INCREMENTAL) ? err2 : err0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (err_ready) begin
      prod_valid <= err_valid;
    end
  end

  // Three independent multiplies
  always_ff @(posedge clk) begin
    if (err_ready && err_valid) begin
      prod0    <= mul_q(gain0, err0);
      prod1    <= mul_q(gain1, err1);
      prod2    <= mul_q(gain2, tap2_err);
      prod_err <= err0;
    end
  end

endmodule

[sv/pidpi_acc.sv]
module pidpi_acc #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         loop_mode,
  input  logic signed [DATA_WIDTH-1:0] output_minimum,
  input  logic signed [DATA_WIDTH-1:0] output_maximum,
  input  logic [DATA_WIDTH-2:0]        integral_limit,
  input  logic                         prod_valid,
  input  logic signed [DATA_WIDTH-1:0] prod0,
  input  logic signed [DATA_WIDTH-1:0] prod1,
  input  logic signed [DATA_WIDTH-1:0] prod2,
  input  logic signed [DATA_WIDTH-1:0] prod_err,
  output logic                         prod_ready,
  pidpi_drive_if.source                drive
);
  import pidpi_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic                out_valid;
  logic signed [W-1:0] out_value;
  logic signed [W-1:0] accumulator;
  logic signed [W-1:0] accumulator_next;
  logic signed [W-1:0] result;
  logic signed [W:0]   acc_wide;
  logic signed [W:0]   lim_wide;
  logic                within_limit;
  logic                opposed;

  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) add_s = s[W] ? SMIN : SMAX;
    else add_s = s[W-1:0];
  endfunction

  // When the bounds cross, values above the maximum give the maximum, all others the minimum
  function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] v,
                                                input logic signed [W-1:0] lo,
                                                input logic signed [W-1:0] hi);
    if (v > hi) clamp = hi;
    else if (v < lo) clamp = lo;
    else clamp = v;
  endfunction

  assign prod_ready = !out_valid || drive.ready;

  // Anti-windup test on the integral
  assign acc_wide     = $signed({accumulator[W-1], accumulator});
  assign lim_wide     = $signed({2'b00, integral_limit});
  assign within_limit = (acc_wide > -lim_wide) && (acc_wide < lim_wide);
  assign opposed      = (accumulator > 0 && prod_err < 0) ||
                        (accumulator < 0 && prod_err > 0);

  // Accumulate and clamp
  always_comb begin
    if (loop_mode == MODE_INCREMENTAL) begin
      accumulator_next = clamp(add_s(add_s(add_s(accumulator, prod0), prod1), prod2),
                               output_minimum, output_maximum);
      result           = accumulator_next;
    end else begin
      accumulator_next = (within_limit || opposed) ? add_s(accumulator, prod2)
                                                   : accumulator;
      result           = clamp(add_s(add_s(prod0, prod1), accumulator_next),
                               output_minimum, output_maximum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      accumulator <= '0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
      if (prod_valid) accumulator <= accumulator_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      out_value <= result;
    end
  end

  assign drive.valid       = out_valid;
  assign drive.drive_value = out_value;

endmodule
